### src/set_assoc_cache_tag_store_top_assert.svh
`ifndef SET_ASSOC_CACHE_TAG_STORE_TOP_ASSERT_SVH
`define SET_ASSOC_CACHE_TAG_STORE_TOP_ASSERT_SVH

// check a consequence in the same cycle
`define SCS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scs: same-cycle check failed");

// check a consequence in the next cycle
`define SCS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scs: next-cycle check failed");

`endif

### src/scs_pkg.sv
package scs_pkg;

	localparam int SCS_MAX_WAYS     = 8;
	localparam int SCS_MAX_SET_BITS = 8;
	localparam int SCS_ADDRESS_BITS = 32;

	localparam int SCS_STAMP_W   = 32;
	localparam int SCS_CFG_W     = 4;
	localparam int SCS_CFG_IDX_W = 2;
	localparam logic [SCS_CFG_W-1:0] SCS_OFFSET_LIMIT = 4'd12;

	localparam logic [SCS_CFG_W-1:0] SCS_OFFSET_RESET = 4'd5;
	localparam logic [SCS_CFG_W-1:0] SCS_INDEX_RESET  = 4'd8;
	localparam logic [SCS_CFG_W-1:0] SCS_WAYS_RESET   = 4'd8;

	typedef enum logic [SCS_CFG_IDX_W-1:0] {
		CFG_OFFSET_BITS,
		CFG_INDEX_BITS,
		CFG_WAYS_IN_USE
	} scs_cfg_idx_t;

	typedef enum logic {
		REQ_LOOKUP = 1'b0,
		REQ_FILL   = 1'b1
	} scs_req_kind_t;

	typedef struct packed {
		logic        req_type;
		logic [31:0] address;
	} scs_req_t;

	typedef struct packed {
		logic        hit;
		logic [2:0]  victim_way;
		logic [31:0] hit_total;
		logic [31:0] miss_total;
	} scs_rsp_t;

endpackage

### src/scs_if.sv
interface scs_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### src/scs_ram.sv
module scs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

### src/set_assoc_cache_tag_store_top.sv
// An accepted word loads the stage-one registers, then the result register when stage one fires.
// Throughput: one word per cycle unless a held result is not taken; the set row is read from the
// tag RAM at acceptance and written back when a fill leaves stage one, with a one-row bypass for
// back-to-back sets.
// Reset: arst_n clears handshake state, counters and the per-set row valid flags and resets the
// configuration at once; the tag RAM is not cleared and no clearing pass is needed.
module set_assoc_cache_tag_store_top
	import scs_pkg::*;
#(
	parameter int MAX_WAYS     = SCS_MAX_WAYS,
	parameter int MAX_SET_BITS = SCS_MAX_SET_BITS,
	parameter int ADDRESS_BITS = SCS_ADDRESS_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [SCS_CFG_IDX_W-1:0] cfg_index,
	input  logic [SCS_CFG_W-1:0]     cfg_data,
	scs_if.sink                      req,
	scs_if.source                    rsp
);
`include "set_assoc_cache_tag_store_top_assert.svh"

	localparam int NUM_SETS = 1 << MAX_SET_BITS;
	localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int TREE_N   = 1 << WAY_W;
	localparam int TAG_BASE = MAX_WAYS;
	localparam int STP_BASE = MAX_WAYS * (1 + ADDRESS_BITS);
	localparam int ROW_W    = MAX_WAYS * (1 + ADDRESS_BITS + SCS_STAMP_W) + SCS_STAMP_W;

	logic [SCS_CFG_W-1:0] cfg_offset_q, cfg_index_bits_q, cfg_ways_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_offset_q     <= SCS_OFFSET_RESET;
			cfg_index_bits_q <= SCS_INDEX_RESET;
			cfg_ways_q       <= SCS_WAYS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_OFFSET_BITS: cfg_offset_q     <= cfg_data;
				CFG_INDEX_BITS:  cfg_index_bits_q <= cfg_data;
				CFG_WAYS_IN_USE: cfg_ways_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// address split
	logic [SCS_CFG_W-1:0]    off_c, idx_c;
	logic [SCS_CFG_W:0]      tag_shift_c;
	logic [ADDRESS_BITS-1:0] addr_c, tag_c, shifted_c;
	logic [SET_W-1:0]        set_mask_c, set_c;

	always_comb begin
		off_c       = (cfg_offset_q > SCS_OFFSET_LIMIT) ? SCS_OFFSET_LIMIT : cfg_offset_q;
		idx_c       = (cfg_index_bits_q > SCS_CFG_W'(MAX_SET_BITS)) ?
			SCS_CFG_W'(MAX_SET_BITS) : cfg_index_bits_q;
		addr_c      = req.data.address[ADDRESS_BITS-1:0];
		shifted_c   = addr_c >> off_c;
		set_mask_c  = SET_W'((SET_W'(1) << idx_c) - SET_W'(1));
		set_c       = SET_W'(shifted_c) & set_mask_c;
		tag_shift_c = {1'b0, off_c} + {1'b0, idx_c};
		tag_c       = addr_c >> tag_shift_c;
	end

	// handshake
	logic s1_valid_q, s2_valid_q, s1_fire, acc, we;

	assign s1_fire   = s1_valid_q && (!s2_valid_q || rsp.ready);
	assign req.ready = !s1_valid_q || s1_fire;
	assign acc       = req.valid && req.ready;

	// stage one registers
	logic                    type_s1, rowv_s1, fwd_use_s1;
	logic [SET_W-1:0]        set_s1;
	logic [ADDRESS_BITS-1:0] tag_s1;
	logic [ROW_W-1:0]        fwd_row_s1, wrow, rdata;
	logic [NUM_SETS-1:0]     row_valid_q;

	assign we = s1_fire && (type_s1 == REQ_FILL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			fwd_use_s1  <= 1'b0;
			row_valid_q <= '0;
		end else begin
			if (acc) begin
				s1_valid_q <= 1'b1;
				fwd_use_s1 <= we && (set_c == set_s1);
			end else if (s1_fire) begin
				s1_valid_q <= 1'b0;
			end
			if (we) begin
				row_valid_q[set_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			type_s1    <= req.data.req_type;
			set_s1     <= set_c;
			tag_s1     <= tag_c;
			rowv_s1    <= row_valid_q[set_c];
			fwd_row_s1 <= wrow;
		end
	end

	scs_ram #(
		.WIDTH (ROW_W),
		.DEPTH (NUM_SETS)
	) u_row_ram (
		.clk   (clk),
		.we    (we),
		.waddr (set_s1),
		.wdata (wrow),
		.re    (acc),
		.raddr (set_c),
		.rdata (rdata)
	);

	// stage one: search, victim choice, row update
	logic [ROW_W-1:0]        row_cur;
	logic                    row_live, hit_c, inv_found;
	logic [MAX_WAYS-1:0]     vld, active;
	logic [ADDRESS_BITS-1:0] tags [MAX_WAYS];
	logic [SCS_STAMP_W-1:0]  stamps [MAX_WAYS];
	logic [SCS_STAMP_W-1:0]  clock_c;
	logic [SCS_CFG_W:0]      ways_c;
	logic [WAY_W-1:0]        inv_idx, victim_c;
	logic [SCS_STAMP_W:0]    key [TREE_N];
	logic [WAY_W-1:0]        kid [TREE_N];

	always_comb begin
		row_cur  = fwd_use_s1 ? fwd_row_s1 : rdata;
		row_live = fwd_use_s1 || rowv_s1;
		for (int w = 0; w < MAX_WAYS; w++) begin
			vld[w]    = row_live && row_cur[w];
			tags[w]   = row_cur[TAG_BASE + w*ADDRESS_BITS +: ADDRESS_BITS];
			stamps[w] = row_cur[STP_BASE + w*SCS_STAMP_W +: SCS_STAMP_W];
		end
		clock_c = row_live ? row_cur[ROW_W-1 -: SCS_STAMP_W] : '0;

		ways_c = {1'b0, cfg_ways_q};
		if (ways_c == '0) begin
			ways_c = (SCS_CFG_W+1)'(1);
		end
		if (ways_c > (SCS_CFG_W+1)'(MAX_WAYS)) begin
			ways_c = (SCS_CFG_W+1)'(MAX_WAYS);
		end

		hit_c     = 1'b0;
		inv_found = 1'b0;
		inv_idx   = '0;
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			active[w] = ways_c > (SCS_CFG_W+1)'(w);
			if (active[w] && vld[w] && (tags[w] == tag_s1)) begin
				hit_c = 1'b1;
			end
			if (active[w] && !vld[w]) begin
				inv_found = 1'b1;
				inv_idx   = WAY_W'(w);
			end
		end

		// oldest stamp, lower way wins a tie
		for (int i = 0; i < TREE_N; i++) begin
			kid[i] = WAY_W'(i);
			key[i] = '1;
			if (i < MAX_WAYS) begin
				if (active[i]) begin
					key[i] = {1'b0, stamps[i]};
				end
			end
		end
		for (int l = 0; l < WAY_W; l++) begin
			for (int i = 0; i < TREE_N; i += (2 << l)) begin
				if (key[i + (1 << l)] < key[i]) begin
					key[i] = key[i + (1 << l)];
					kid[i] = kid[i + (1 << l)];
				end
			end
		end
		victim_c = inv_found ? inv_idx : kid[0];

		wrow = row_cur;
		for (int w = 0; w < MAX_WAYS; w++) begin
			wrow[w] = vld[w] || (victim_c == WAY_W'(w));
			if (victim_c == WAY_W'(w)) begin
				wrow[TAG_BASE + w*ADDRESS_BITS +: ADDRESS_BITS] = tag_s1;
				wrow[STP_BASE + w*SCS_STAMP_W +: SCS_STAMP_W]   = clock_c;
			end
		end
		wrow[ROW_W-1 -: SCS_STAMP_W] = clock_c + SCS_STAMP_W'(1);
	end

	// counters and result register
	logic [31:0] hit_q, miss_q, hit_nxt, miss_nxt;
	logic        hit_s2;
	logic [2:0]  victim_s2;
	logic [31:0] hit_total_s2, miss_total_s2;

	always_comb begin
		hit_nxt  = hit_q;
		miss_nxt = miss_q;
		if (type_s1 == REQ_LOOKUP) begin
			if (hit_c) begin
				hit_nxt = hit_q + 32'd1;
			end else begin
				miss_nxt = miss_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q      <= '0;
			miss_q     <= '0;
			s2_valid_q <= 1'b0;
		end else begin
			if (s1_fire) begin
				hit_q      <= hit_nxt;
				miss_q     <= miss_nxt;
				s2_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				s2_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			hit_s2        <= (type_s1 == REQ_LOOKUP) && hit_c;
			victim_s2     <= (type_s1 == REQ_FILL) ? 3'(victim_c) : 3'd0;
			hit_total_s2  <= hit_nxt;
			miss_total_s2 <= miss_nxt;
		end
	end

	assign rsp.valid           = s2_valid_q;
	assign rsp.data.hit        = hit_s2;
	assign rsp.data.victim_way = victim_s2;
	assign rsp.data.hit_total  = hit_total_s2;
	assign rsp.data.miss_total = miss_total_s2;

	`SCS_ASSERT_NEXT(a_count_step, s1_fire && (type_s1 == REQ_LOOKUP), 32'(hit_q + miss_q) == 32'($past(hit_q) + $past(miss_q) + 32'd1))
	`SCS_ASSERT_NEXT(a_fire_shows, s1_fire, rsp.valid)
	`SCS_ASSERT_NOW(a_stall_cause, !req.ready, s1_valid_q && s2_valid_q && !rsp.ready)
	`SCS_ASSERT_NEXT(a_fill_marks_row, we, row_valid_q[$past(set_s1)])

endmodule
